### rtl/core/gbca_pkg.sv
// Shared constants and codes for the gyro bias calibration averager.
package gbca_pkg;

  localparam int CNT_W            = 16;
  localparam int DUR_W            = 16;
  localparam int TIME_W           = 32;
  localparam int GYRO_W           = 16;
  localparam int STATUS_W         = 3;
  localparam int NUM_AXES         = 6;

  localparam int MAX_SAMPLES_DEF  = 65535;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam logic [DUR_W-1:0] DURATION_RESET = 16'd5000;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] SEL_FIRST   = 2'd0;
  localparam logic [1:0] SEL_SECOND  = 2'd1;
  localparam logic [1:0] SEL_BOTH    = 2'd2;
  localparam logic [1:0] SEL_INVALID = 2'd3;

  localparam logic [STATUS_W-1:0] ST_STARTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ACCUM    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd5;

endpackage

### rtl/core/gyro_bias_calibration_averager_unit.sv
// Gyro bias calibration averager: accumulation, deadline check and shared serial divider.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+-------------------------------
//  input   | in_cmd, in_time_ms, in_imu_select, in_gyro*  | accepted when start & !busy
//  result  | out_status, out_bias*, out_update1/2         | out_strobe, one cycle, no stall
//  config  | cfg_wdata (duration_ms)                      | written when cfg_we
//
// Starts, rejects, idle samples, accumulating samples and failed finishing samples strobe
// their result on the following cycle and busy stays low.
// A finishing sample that succeeds runs six divisions through one restoring divider;
// busy is high meanwhile.
// Synchronous active-low reset clears run state, sums, counts and sets duration to 5000.
// The receiver cannot stall; each result is shown for exactly one cycle.
module gyro_bias_calibration_averager_unit #(
  parameter int MAX_SAMPLES = gbca_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = gbca_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_cmd,
  input  logic        [gbca_pkg::TIME_W-1:0]   in_time_ms,
  input  logic        [1:0]                    in_imu_select,
  input  logic signed [gbca_pkg::GYRO_W-1:0]   in_gyro1_x,
  input  logic signed [gbca_pkg::GYRO_W-1:0]   in_gyro1_y,
  input  logic signed [gbca_pkg::GYRO_W-1:0]   in_gyro1_z,
  input  logic                                 in_valid1,
  input  logic signed [gbca_pkg::GYRO_W-1:0]   in_gyro2_x,
  input  logic signed [gbca_pkg::GYRO_W-1:0]   in_gyro2_y,
  input  logic signed [gbca_pkg::GYRO_W-1:0]   in_gyro2_z,
  input  logic                                 in_valid2,
  output logic                                 out_strobe,
  output logic        [gbca_pkg::STATUS_W-1:0] out_status,
  output logic signed [gbca_pkg::GYRO_W-1:0]   out_bias1_x,
  output logic signed [gbca_pkg::GYRO_W-1:0]   out_bias1_y,
  output logic signed [gbca_pkg::GYRO_W-1:0]   out_bias1_z,
  output logic signed [gbca_pkg::GYRO_W-1:0]   out_bias2_x,
  output logic signed [gbca_pkg::GYRO_W-1:0]   out_bias2_y,
  output logic signed [gbca_pkg::GYRO_W-1:0]   out_bias2_z,
  output logic                                 out_update1,
  output logic                                 out_update2,
  input  logic                                 cfg_we,
  input  logic        [gbca_pkg::DUR_W-1:0]    cfg_wdata
);

  localparam int ACC_W  = SAMPLE_BITS + gbca_pkg::CNT_W;
  localparam int BCNT_W = $clog2(ACC_W);
  localparam int GW     = gbca_pkg::GYRO_W;
  localparam int CW     = gbca_pkg::CNT_W;
  localparam logic [CW-1:0]     MAX_CNT   = CW'(MAX_SAMPLES);
  localparam logic [BCNT_W-1:0] LAST_BIT  = BCNT_W'(ACC_W - 1);
  localparam logic [2:0]        LAST_AXIS = 3'(gbca_pkg::NUM_AXES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;

  function automatic logic signed [ACC_W-1:0] ext_sample(input logic [GW-1:0] p);
    logic [ACC_W-1:0] w;
    logic [ACC_W-1:0] m;
    w = {{(ACC_W-GW){1'b0}}, p};
    m = (ACC_W'(1) << SAMPLE_BITS) - ACC_W'(1);
    w = w & m;
    if (w[SAMPLE_BITS-1]) w = w | ~m;
    return w;
  endfunction

  logic [1:0]                   state_r, state_nxt;
  logic                         running_r, running_nxt;
  logic [1:0]                   sel_r, sel_nxt;
  logic [gbca_pkg::TIME_W-1:0]  deadline_r, deadline_nxt;
  logic [CW-1:0]                cnt1_r, cnt1_nxt;
  logic [CW-1:0]                cnt2_r, cnt2_nxt;
  logic signed [ACC_W-1:0]      sum_r [gbca_pkg::NUM_AXES];
  logic signed [ACC_W-1:0]      sum_nxt [gbca_pkg::NUM_AXES];
  logic [gbca_pkg::DUR_W-1:0]   dur_r;

  logic [2:0]                   axis_r, axis_nxt;
  logic [BCNT_W-1:0]            bcnt_r, bcnt_nxt;
  logic [ACC_W-1:0]             dvd_r, dvd_nxt;
  logic [CW:0]                  rem_r, rem_nxt;
  logic [CW-1:0]                dvs_r, dvs_nxt;
  logic                         neg_r, neg_nxt;
  logic signed [GW-1:0]         bias_r [gbca_pkg::NUM_AXES];
  logic signed [GW-1:0]         bias_nxt [gbca_pkg::NUM_AXES];

  logic                         strobe_r, strobe_nxt;
  logic [gbca_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic                         accept;
  logic                         use1, use2, add1, add2;
  logic [gbca_pkg::TIME_W-1:0]  diff;
  logic signed [ACC_W-1:0]      cur_sum;
  logic [CW:0]                  rem_sh;
  logic                         q_bit;
  logic [GW-1:0]                q_low;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign use1   = (sel_r == gbca_pkg::SEL_FIRST)  || (sel_r == gbca_pkg::SEL_BOTH);
  assign use2   = (sel_r == gbca_pkg::SEL_SECOND) || (sel_r == gbca_pkg::SEL_BOTH);
  assign add1   = use1 && in_valid1 && (cnt1_r < MAX_CNT);
  assign add2   = use2 && in_valid2 && (cnt2_r < MAX_CNT);
  assign diff   = in_time_ms - deadline_r;
  assign cur_sum = sum_r[axis_r];
  assign rem_sh = {rem_r[CW-1:0], dvd_r[ACC_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dvs_r});
  assign q_low  = neg_r ? (GW'(0) - dvd_nxt[GW-1:0]) : dvd_nxt[GW-1:0];

  always_comb begin
    state_nxt    = state_r;
    running_nxt  = running_r;
    sel_nxt      = sel_r;
    deadline_nxt = deadline_r;
    cnt1_nxt     = cnt1_r;
    cnt2_nxt     = cnt2_r;
    sum_nxt      = sum_r;
    axis_nxt     = axis_r;
    bcnt_nxt     = bcnt_r;
    dvd_nxt      = dvd_r;
    rem_nxt      = rem_r;
    dvs_nxt      = dvs_r;
    neg_nxt      = neg_r;
    bias_nxt     = bias_r;
    strobe_nxt   = 1'b0;
    status_nxt   = status_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          strobe_nxt = 1'b1;
          if (in_cmd == gbca_pkg::CMD_START) begin
            if (in_imu_select == gbca_pkg::SEL_INVALID || running_r) begin
              status_nxt = gbca_pkg::ST_REJECTED;
            end else begin
              for (int i = 0; i < gbca_pkg::NUM_AXES; i++) sum_nxt[i] = '0;
              cnt1_nxt     = '0;
              cnt2_nxt     = '0;
              running_nxt  = 1'b1;
              sel_nxt      = in_imu_select;
              deadline_nxt = in_time_ms + {{(gbca_pkg::TIME_W-gbca_pkg::DUR_W){1'b0}}, dur_r};
              status_nxt   = gbca_pkg::ST_STARTED;
            end
          end else if (!running_r) begin
            status_nxt = gbca_pkg::ST_IDLE;
          end else begin
            if (add1) begin
              sum_nxt[0] = sum_r[0] + ext_sample(in_gyro1_x);
              sum_nxt[1] = sum_r[1] + ext_sample(in_gyro1_y);
              sum_nxt[2] = sum_r[2] + ext_sample(in_gyro1_z);
              cnt1_nxt   = cnt1_r + CW'(1);
            end
            if (add2) begin
              sum_nxt[3] = sum_r[3] + ext_sample(in_gyro2_x);
              sum_nxt[4] = sum_r[4] + ext_sample(in_gyro2_y);
              sum_nxt[5] = sum_r[5] + ext_sample(in_gyro2_z);
              cnt2_nxt   = cnt2_r + CW'(1);
            end
            if (diff[gbca_pkg::TIME_W-1]) begin
              status_nxt = gbca_pkg::ST_ACCUM;
            end else begin
              running_nxt = 1'b0;
              if ((use1 && cnt1_nxt == '0) || (use2 && cnt2_nxt == '0)) begin
                status_nxt = gbca_pkg::ST_FAILED;
              end else begin
                strobe_nxt = 1'b0;
                axis_nxt   = '0;
                state_nxt  = S_LOAD;
              end
            end
          end
        end
      end
      S_LOAD: begin
        neg_nxt  = cur_sum[ACC_W-1];
        dvd_nxt  = cur_sum[ACC_W-1] ? (ACC_W'(0) - cur_sum) : cur_sum;
        rem_nxt  = '0;
        dvs_nxt  = (axis_r < 3'd3) ? cnt1_r : cnt2_r;
        bcnt_nxt = '0;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        rem_nxt  = q_bit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
        dvd_nxt  = {dvd_r[ACC_W-2:0], q_bit};
        bcnt_nxt = bcnt_r + BCNT_W'(1);
        if (bcnt_r == LAST_BIT) begin
          bias_nxt[axis_r] = q_low;
          if (axis_r == LAST_AXIS) begin
            strobe_nxt = 1'b1;
            status_nxt = gbca_pkg::ST_DONE;
            state_nxt  = S_IDLE;
          end else begin
            axis_nxt  = axis_r + 3'd1;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      running_r  <= 1'b0;
      sel_r      <= gbca_pkg::SEL_FIRST;
      deadline_r <= '0;
      cnt1_r     <= '0;
      cnt2_r     <= '0;
      for (int i = 0; i < gbca_pkg::NUM_AXES; i++) sum_r[i] <= '0;
      dur_r      <= gbca_pkg::DURATION_RESET;
      strobe_r   <= 1'b0;
      status_r   <= gbca_pkg::ST_IDLE;
    end else begin
      state_r    <= state_nxt;
      running_r  <= running_nxt;
      sel_r      <= sel_nxt;
      deadline_r <= deadline_nxt;
      cnt1_r     <= cnt1_nxt;
      cnt2_r     <= cnt2_nxt;
      sum_r      <= sum_nxt;
      if (cfg_we) dur_r <= cfg_wdata;
      strobe_r   <= strobe_nxt;
      status_r   <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axis_r <= axis_nxt;
    bcnt_r <= bcnt_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    bias_r <= bias_nxt;
  end

  logic done_out;
  assign done_out    = strobe_r && (status_r == gbca_pkg::ST_DONE);
  assign out_strobe  = strobe_r;
  assign out_status  = status_r;
  assign out_update1 = done_out && use1;
  assign out_update2 = done_out && use2;
  assign out_bias1_x = out_update1 ? bias_r[0] : '0;
  assign out_bias1_y = out_update1 ? bias_r[1] : '0;
  assign out_bias1_z = out_update1 ? bias_r[2] : '0;
  assign out_bias2_x = out_update2 ? bias_r[3] : '0;
  assign out_bias2_y = out_update2 ? bias_r[4] : '0;
  assign out_bias2_z = out_update2 ? bias_r[5] : '0;

  a_done_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_strobe && out_status == gbca_pkg::ST_DONE)
    else $error("divider finished without a done word");

  a_reject_running: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_cmd == gbca_pkg::CMD_START && running_r
    |=> out_strobe && out_status == gbca_pkg::ST_REJECTED && running_r)
    else $error("start while running was not rejected");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt1_r <= MAX_CNT && cnt2_r <= MAX_CNT)
    else $error("sample count exceeded saturation limit");

  a_busy_not_running: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !running_r && !out_strobe)
    else $error("busy while a run is open or a word is shown");

  a_update_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_update1 || out_update2) |-> out_strobe)
    else $error("update flag outside a done word");

endmodule
